[hw/rtl/page_aligned_free_region_finder_assert.svh]
// Assertion macros for the page-aligned free region finder.
// Defining NO_ASSERTIONS leaves every macro with an empty body.
`ifndef PAGE_ALIGNED_FREE_REGION_FINDER_ASSERT_SVH
`define PAGE_ALIGNED_FREE_REGION_FINDER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PAFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PAFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PAFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define PAFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[hw/rtl/pafr_pkg.sv]
// Shared types and constants of the page-aligned free region finder.
// No dependencies; every RTL module imports it.
package pafr_pkg;

    localparam int ADDR_W     = 64;
    localparam int REQ_W      = 32;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 64;

    localparam logic [1:0] REG_REQUEST_LENGTH = 2'd0;
    localparam logic [1:0] REG_ADDRESS_LIMIT  = 2'd1;
    localparam logic [1:0] REG_HIGHEST_MODE   = 2'd2;

    localparam logic [ADDR_W-1:0] LIMIT_RESET = 64'h0000_0001_0000_0000;

    typedef struct packed {
        logic              cand;
        logic [ADDR_W-1:0] nbase;
        logic [ADDR_W-1:0] start;
        logic              first;
        logic              last;
    } t_entry;

    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [ADDR_W-1:0] limit;
        logic [ADDR_W-1:0] lim_m_req;
        logic              lim_gt_req;
        logic              highest;
    } t_cfg;

endpackage

[hw/rtl/page_aligned_free_region_finder.sv]
// A result is registered after the entry marked last passes the three-stage alignment pipeline
// and the queue. One map entry is taken per cycle while the queue has credit; a result not yet
// taken holds back only the next last entry.
// The derived configuration values are registered from the configuration registers.
// Synchronous active-low reset clears the search state, the queue and the pipeline valid bits,
// and loads request_length 0, address_limit 2^32 and highest_mode 1.
`include "page_aligned_free_region_finder_assert.svh"
module page_aligned_free_region_finder #(
    parameter int PAGE_BITS   = 12,
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pafr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [pafr_pkg::APB_DATA_W-1:0] pwdata,
    output logic [pafr_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // region_base [63:0], region_length [127:64]
    input  logic [127:0]                    s_tdata,
    // region_available [0], first_entry [1]
    input  logic [1:0]                      s_tuser,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // block_start [63:0], granted_length [95:64]
    output logic [95:0]                     m_tdata,
    // found [0]
    output logic                            m_tuser
);
    import pafr_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int OW = CW + 2;

    logic [REQ_W-1:0]  r_req;
    logic [ADDR_W-1:0] r_limit;
    logic              r_highest;
    logic [ADDR_W-1:0] r_lim_m_req;
    logic              r_lim_gt_req;
    t_cfg              cfg;

    logic              wr_en;
    logic              s_fire;
    logic              f_valid;
    t_entry            f_entry;
    logic [1:0]        f_inflight;
    logic              q_valid, q_pop;
    t_entry            q_entry;
    logic [CW-1:0]     q_count;
    logic              b_found;
    logic [ADDR_W-1:0] b_start;
    logic [REQ_W-1:0]  b_granted;

    assign wr_en  = psel & penable & pwrite & pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req     <= '0;
            r_limit   <= LIMIT_RESET;
            r_highest <= 1'b1;
        end else if (wr_en) begin
            unique case (paddr[4:3])
                REG_REQUEST_LENGTH: r_req     <= pwdata[REQ_W-1:0];
                REG_ADDRESS_LIMIT:  r_limit   <= pwdata;
                REG_HIGHEST_MODE:   r_highest <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_lim_m_req  <= r_limit - {32'd0, r_req};
        r_lim_gt_req <= r_limit > {32'd0, r_req};
    end

    always_comb begin
        unique case (paddr[4:3])
            REG_REQUEST_LENGTH: prdata = {32'd0, r_req};
            REG_ADDRESS_LIMIT:  prdata = r_limit;
            REG_HIGHEST_MODE:   prdata = {63'd0, r_highest};
            default:            prdata = '0;
        endcase
    end

    assign cfg.req        = r_req;
    assign cfg.limit      = r_limit;
    assign cfg.lim_m_req  = r_lim_m_req;
    assign cfg.lim_gt_req = r_lim_gt_req;
    assign cfg.highest    = r_highest;

    assign s_tready = i_rst_n & (({2'b00, q_count} + OW'(f_inflight)) < OW'(QUEUE_DEPTH));
    assign s_fire   = s_tvalid & s_tready;

    pafr_front #(
        .PAGE_BITS (PAGE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_fire),
        .i_base     (s_tdata[63:0]),
        .i_len      (s_tdata[127:64]),
        .i_avail    (s_tuser[0]),
        .i_first    (s_tuser[1]),
        .i_last     (s_tlast),
        .i_cfg      (cfg),
        .o_valid    (f_valid),
        .o_entry    (f_entry),
        .o_inflight (f_inflight)
    );

    pafr_queue #(
        .DEPTH (QUEUE_DEPTH),
        .CW    (CW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_entry (f_entry),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (q_entry),
        .o_count (q_count)
    );

    pafr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_entry    (q_entry),
        .i_cfg      (cfg),
        .i_m_tready (m_tready),
        .o_pop      (q_pop),
        .o_m_tvalid (m_tvalid),
        .o_found    (b_found),
        .o_start    (b_start),
        .o_granted  (b_granted)
    );

    assign m_tdata = {b_granted, b_start};
    assign m_tuser = b_found;

    `PAFR_ASSERT_NOW(a_queue_no_overflow, i_clk, i_rst_n, 1'b1, (int'(q_count) + int'(f_inflight)) <= QUEUE_DEPTH, "queue credit exceeded")
    `PAFR_ASSERT_NOW(a_not_found_zero, i_clk, i_rst_n, m_tvalid && !m_tuser, m_tdata == '0, "result fields not cleared when nothing found")
    `PAFR_ASSERT_NEXT(a_empty_queue_no_pop, i_clk, i_rst_n, !q_valid && !f_valid, !q_pop, "pop from an empty queue")

endmodule

[hw/rtl/pafr_front.sv]
// Front end: a three-stage pipeline that aligns each map entry and classifies it.
// Depends on pafr_pkg; feeds pafr_queue.
module pafr_front #(
    parameter int PAGE_BITS = 12
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [pafr_pkg::ADDR_W-1:0] i_base,
    input  logic [pafr_pkg::ADDR_W-1:0] i_len,
    input  logic                     i_avail,
    input  logic                     i_first,
    input  logic                     i_last,
    input  pafr_pkg::t_cfg           i_cfg,
    output logic                     o_valid,
    output pafr_pkg::t_entry         o_entry,
    output logic [1:0]               o_inflight
);
    import pafr_pkg::*;

    localparam logic [ADDR_W-1:0] MASK = (64'd1 << PAGE_BITS) - 64'd1;

    logic [ADDR_W:0]   n_sum;
    logic [ADDR_W-1:0] n_skip;
    logic [ADDR_W-1:0] n_alen;
    logic              n_drop;
    logic              n_cand;
    logic [ADDR_W:0]   n_top;
    logic              n_clamp;
    logic [ADDR_W-1:0] n_start;

    logic              r_v1, r_v2, r_v3;
    logic [ADDR_W-1:0] r_nbase1, r_alen1, r_nbase2;
    logic              r_drop1, r_first1, r_last1;
    logic              r_cand2, r_first2, r_last2;
    logic [ADDR_W:0]   r_top2;
    t_entry            r_ent3;

    always_comb begin
        n_sum  = {1'b0, i_base} + {1'b0, MASK};
        n_skip = (~i_base + 64'd1) & MASK;
        n_alen = (i_len - n_skip) & ~MASK;
        n_drop = n_sum[ADDR_W] | (n_skip > i_len) | ~i_avail;
    end

    always_comb begin
        n_cand = !r_drop1 && i_cfg.lim_gt_req
                 && (r_alen1 >= {32'd0, i_cfg.req})
                 && (r_nbase1 <= i_cfg.lim_m_req);
        n_top  = {1'b0, r_nbase1} + {1'b0, r_alen1};
    end

    always_comb begin
        n_clamp = r_top2[ADDR_W] || (r_top2[ADDR_W-1:0] > i_cfg.limit);
        n_start = n_clamp ? i_cfg.lim_m_req : (r_top2[ADDR_W-1:0] - {32'd0, i_cfg.req});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nbase1      <= n_sum[ADDR_W-1:0] & ~MASK;
        r_alen1       <= n_alen;
        r_drop1       <= n_drop;
        r_first1      <= i_first;
        r_last1       <= i_last;
        r_cand2       <= n_cand;
        r_nbase2      <= r_nbase1;
        r_top2        <= n_top;
        r_first2      <= r_first1;
        r_last2       <= r_last1;
        r_ent3.cand   <= r_cand2;
        r_ent3.nbase  <= r_nbase2;
        r_ent3.start  <= n_start;
        r_ent3.first  <= r_first2;
        r_ent3.last   <= r_last2;
    end

    assign o_valid    = r_v3;
    assign o_entry    = r_ent3;
    assign o_inflight = {1'b0, r_v1} + {1'b0, r_v2} + {1'b0, r_v3};

endmodule

[hw/rtl/pafr_queue.sv]
// Short first-in first-out queue between the classifying front end and the search back end.
// Depends on pafr_pkg for the entry type.
module pafr_queue #(
    parameter int DEPTH = 4,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pafr_pkg::t_entry i_entry,
    input  logic             i_pop,
    output logic             o_valid,
    output pafr_pkg::t_entry o_entry,
    output logic [CW-1:0]    o_count
);
    import pafr_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

    t_entry        r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_IDX) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_IDX) ? '0 : r_rd + 1'b1;
            end
            r_count <= r_count + {{(CW-1){1'b0}}, i_push} - {{(CW-1){1'b0}}, i_pop};
        end
    end

    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd];
    assign o_count = r_count;

endmodule

[hw/rtl/pafr_back.sv]
// Back end: holds the search state, applies each classified entry and registers the result.
// Depends on pafr_pkg; drains pafr_queue.
module pafr_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  pafr_pkg::t_entry            i_entry,
    input  pafr_pkg::t_cfg              i_cfg,
    input  logic                        i_m_tready,
    output logic                        o_pop,
    output logic                        o_m_tvalid,
    output logic                        o_found,
    output logic [pafr_pkg::ADDR_W-1:0] o_start,
    output logic [pafr_pkg::REQ_W-1:0]  o_granted
);
    import pafr_pkg::*;

    logic              r_have, r_closed;
    logic [ADDR_W-1:0] r_best;
    logic              r_out_valid, r_found;
    logic [ADDR_W-1:0] r_start;
    logic [REQ_W-1:0]  r_granted;

    logic              n_have, n_closed, n_take;
    logic [ADDR_W-1:0] n_best;
    logic              eff_have, eff_closed;
    logic [ADDR_W-1:0] eff_best;
    logic              out_free;

    always_comb begin
        eff_have   = i_entry.first ? 1'b0 : r_have;
        eff_closed = i_entry.first ? 1'b0 : r_closed;
        eff_best   = i_entry.first ? '0 : r_best;
        n_take     = !eff_closed && i_entry.cand && !(eff_have && (eff_best > i_entry.nbase));
        n_have     = n_take | eff_have;
        n_best     = n_take ? i_entry.start : eff_best;
        n_closed   = eff_closed | (n_take & ~i_cfg.highest);
    end

    assign out_free = !r_out_valid || i_m_tready;
    assign o_pop    = i_valid && (!i_entry.last || out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have      <= 1'b0;
            r_closed    <= 1'b0;
            r_best      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                if (i_entry.last) begin
                    r_have   <= 1'b0;
                    r_closed <= 1'b0;
                    r_best   <= '0;
                end else begin
                    r_have   <= n_have;
                    r_closed <= n_closed;
                    r_best   <= n_best;
                end
            end
            if (o_pop && i_entry.last) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_entry.last) begin
            r_found   <= n_have;
            r_start   <= n_have ? n_best : '0;
            r_granted <= n_have ? i_cfg.req : '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_found    = r_found;
    assign o_start    = r_start;
    assign o_granted  = r_granted;

endmodule
